FILE: sv/lmcs_pkg.sv
// Package for the LED matrix column scroller.
// Holds the row count, controller addresses, operation codes and shared types.
// No dependencies.
`default_nettype none
package lmcs_pkg;

	localparam int ROWS = 8;
	localparam int CNT_W = 4;
	localparam int INIT_LEN = 14;
	localparam int INIT_FIXED = 5;

	localparam logic [3:0] ADDR_TEST     = 4'hF;
	localparam logic [3:0] ADDR_SHUTDOWN = 4'hC;
	localparam logic [3:0] ADDR_SCAN     = 4'hB;
	localparam logic [3:0] ADDR_BRIGHT   = 4'hA;
	localparam logic [3:0] ADDR_DECODE   = 4'h9;

	localparam logic [0:0] CFG_SCAN_LIMIT = 1'b0;
	localparam logic [0:0] CFG_INTENSITY  = 1'b1;

	typedef enum logic [1:0] {
		OP_SHIFT = 2'd0,
		OP_CLEAR = 2'd1,
		OP_INIT  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		MODE_REFRESH = 1'b0,
		MODE_INIT    = 1'b1
	} seq_mode_t;

	typedef struct packed {
		logic load;
		logic zero;
		logic advance;
	} cell_ctrl_t;

	typedef struct packed {
		logic      start;
		seq_mode_t mode;
	} seq_start_t;

	typedef struct packed {
		logic busy;
		logic fire_last;
	} seq_status_t;

endpackage
`default_nettype wire

FILE: sv/led_matrix_column_scroller.sv
// Top level of the LED matrix column scroller: config registers, row cells, sequencer.
// Depends on lmcs_pkg, lmcs_row_cell and lmcs_write_seq.
//
// Channel   Dir  Contents
// s_*       in   operation word: tdata = column, tuser = operation
// m_*       out  register write word: tdata = address, data; tlast = last of burst
// cfg_*     in   register write: index 0 scan limit, index 1 intensity
//
// A shift or clear word gives eight writes, one per cycle while m_tready is high; an
// init word gives fourteen. The next word is taken in the cycle the final write of
// the burst leaves, so bursts run back to back; m_tready sets the write rate.
// Operation code 3 is accepted and gives no write. Reset zeroes the rows and idles
// the output. A stalled m_tready holds the current write and s_tready stays low.
`default_nettype none
module led_matrix_column_scroller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] column
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [3:0] reg_address, [11:4] reg_data, [15:12] zero
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [3:0]  cfg_wdata
);
	import lmcs_pkg::*;

	logic [2:0]  scan_limit_q;
	logic [3:0]  intensity_q;
	logic        accept;
	op_t         op;
	cell_ctrl_t  ctrl;
	seq_start_t  start;
	seq_status_t status;
	logic [7:0]  snap [ROWS];
	logic [3:0]  reg_address;
	logic [7:0]  reg_data;

	assign op = op_t'(s_tuser);
	assign s_tready = !status.busy | status.fire_last;
	assign accept = s_tvalid & s_tready;

	assign ctrl.load = accept & (op != OP_NONE);
	assign ctrl.zero = (op != OP_SHIFT);
	assign ctrl.advance = m_tvalid & m_tready;
	assign start.start = ctrl.load;
	assign start.mode = (op == OP_INIT) ? MODE_INIT : MODE_REFRESH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= 3'd7;
			intensity_q  <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCAN_LIMIT: scan_limit_q <= cfg_wdata[2:0];
				CFG_INTENSITY:  intensity_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_cell
		logic [7:0] next_in;
		if (r == ROWS - 1) begin : g_tail
			assign next_in = 8'h00;
		end else begin : g_mid
			assign next_in = snap[r+1];
		end
		lmcs_row_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.col_bit (s_tdata[ROWS-1-r]),
			.next_in (next_in),
			.snap    (snap[r])
		);
	end

	lmcs_write_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.head_data   (snap[0]),
		.scan_limit  (scan_limit_q),
		.intensity   (intensity_q),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.reg_address (reg_address),
		.reg_data    (reg_data),
		.last        (m_tlast),
		.status      (status)
	);

	assign m_tdata = {4'h0, reg_data, reg_address};

endmodule
`default_nettype wire

FILE: sv/lmcs_row_cell.sv
// One row cell: keeps a row byte and a snapshot byte that moves toward the head.
// Depends on lmcs_pkg.
`default_nettype none
module lmcs_row_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lmcs_pkg::cell_ctrl_t ctrl,
	input  wire logic               col_bit,
	input  wire logic [7:0]         next_in,
	output logic [7:0]              snap
);
	import lmcs_pkg::*;

	logic [7:0] row_q;
	logic [7:0] snap_q;
	logic [7:0] row_next;

	assign row_next = ctrl.zero ? 8'h00 : {row_q[6:0], col_bit};
	assign snap = snap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= 8'h00;
			snap_q <= 8'h00;
		end else if (ctrl.load) begin
			row_q  <= row_next;
			snap_q <= row_next;
		end else if (ctrl.advance) begin
			snap_q <= next_in;
		end
	end

endmodule
`default_nettype wire

FILE: sv/lmcs_write_seq.sv
// Write sequencer: counts out the register writes of a refresh or init burst.
// Depends on lmcs_pkg.
`default_nettype none
module lmcs_write_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lmcs_pkg::seq_start_t start,
	input  wire logic [7:0]         head_data,
	input  wire logic [2:0]         scan_limit,
	input  wire logic [3:0]         intensity,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [3:0]              reg_address,
	output logic [7:0]              reg_data,
	output logic                    last,
	output lmcs_pkg::seq_status_t   status
);
	import lmcs_pkg::*;

	logic                busy_q;
	seq_mode_t           mode_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                fire;

	assign out_valid = busy_q;
	assign fire = busy_q & out_ready;
	assign status.busy = busy_q;
	assign status.fire_last = fire & last;

	always_comb begin
		reg_address = 4'h0;
		reg_data = 8'h00;
		last = 1'b0;
		unique case (mode_q)
			MODE_REFRESH: begin
				reg_address = cnt_q + 4'd1;
				reg_data = head_data;
				last = (cnt_q == CNT_W'(ROWS - 1));
			end
			MODE_INIT: begin
				last = (cnt_q == CNT_W'(INIT_LEN - 1));
				case (cnt_q)
					4'd0: reg_address = ADDR_TEST;
					4'd1: begin
						reg_address = ADDR_SHUTDOWN;
						reg_data = 8'h01;
					end
					4'd2: begin
						reg_address = ADDR_SCAN;
						reg_data = {5'b0, scan_limit};
					end
					4'd3: begin
						reg_address = ADDR_BRIGHT;
						reg_data = {4'b0, intensity};
					end
					4'd4: reg_address = ADDR_DECODE;
					default: reg_address = cnt_q - CNT_W'(INIT_FIXED);
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= MODE_REFRESH;
			cnt_q  <= '0;
		end else if (start.start) begin
			busy_q <= 1'b1;
			mode_q <= start.mode;
			cnt_q  <= '0;
		end else if (fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire
